// File: src/lfu_pkg.sv
// Shared constants and control types for the LFU frame replacement unit.
`default_nettype none

package lfu_pkg;

   // Frame limit register
   localparam int CSR_WIDTH = 6;
   localparam logic [CSR_WIDTH-1:0] CSR_RESET = 6'd32;

   typedef logic [CSR_WIDTH-1:0] csr_type;

   // Top to engine
   typedef struct packed {
      logic start;     // beat accepted on the request channel
      logic out_free;  // response register can take a result this cycle
   } lfu_ctrl_type;

   // Engine to top
   typedef struct packed {
      logic busy;      // a vote is in progress
      logic done;      // result fields are valid, load the response register
   } lfu_status_type;

endpackage : lfu_pkg

`default_nettype wire

// File: src/lfu_channels.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface lfu_req_if #(
   parameter int ID_WIDTH = 8
);
   logic                valid;
   logic                ready;
   logic [ID_WIDTH-1:0] candidate_id;

   modport source (output valid, output candidate_id, input ready);
   modport sink   (input valid, input candidate_id, output ready);
endinterface : lfu_req_if

interface lfu_rsp_if #(
   parameter int ID_WIDTH    = 8,
   parameter int COUNT_WIDTH = 16,
   parameter int SLOT_WIDTH  = 5
);
   logic                   valid;
   logic                   ready;
   logic [SLOT_WIDTH-1:0]  slot_used;
   logic                   newly_posted;
   logic                   evicted_valid;
   logic [ID_WIDTH-1:0]    evicted_id;
   logic [COUNT_WIDTH-1:0] vote_total;

   modport source (output valid, output slot_used, output newly_posted,
                   output evicted_valid, output evicted_id, output vote_total,
                   input ready);
   modport sink   (input valid, input slot_used, input newly_posted,
                   input evicted_valid, input evicted_id, input vote_total,
                   output ready);
endinterface : lfu_rsp_if

`default_nettype wire

// File: src/lfu_frame_replacement_unit.sv
// Top level of the LFU frame replacement unit: CSR, request handshake, response register.
`default_nettype none

// Each request beat is one vote for a candidate id. The unit keeps SLOTS frames in a
// one-read/one-write RAM; every vote walks the whole table once (one frame per cycle,
// reads registered in the RAM ahead of the compare) to find a matching frame, the lowest
// free frame below the frame limit, and the least-voted frame (oldest posting breaks
// ties). A vote for a posted id bumps its saturating count; a new id goes to the free
// frame or replaces the victim. After an eviction a second pass over the RAM closes up
// the posting ranks of later candidates. Each pass is paced by the single RAM read port,
// one frame per cycle, and a new vote is accepted only once the last result has gone
// into the response register. The response sits in its own register, so the next vote
// is accepted while a result waits; the unit stalls only when a new result is ready and
// the old one has not been taken. csr_wr_data sets the frame limit (reset 32): zero acts
// as one and values above SLOTS act as SLOTS; write it only while no vote is in flight.
// Frames above a lowered limit stay posted and can still be hit or evicted. There is no
// clearing pass: frame valid bits live in flops and clear at reset.

module lfu_frame_replacement_unit #(
   parameter int SLOTS       = 32,
   parameter int ID_WIDTH    = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   lfu_req_if.sink                           req_chan,
   lfu_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_wr_en,
   input  wire lfu_pkg::csr_type             csr_wr_data
);
   import lfu_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   csr_type                frames_ff, frames_in;

   lfu_ctrl_type           ctrl;
   lfu_status_type         status;

   logic [SLOT_W-1:0]      res_slot;
   logic                   res_newly;
   logic                   res_evicted;
   logic [ID_WIDTH-1:0]    res_evicted_id;
   logic [COUNT_WIDTH-1:0] res_total;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic                   rsp_newly_ff, rsp_newly_in;
   logic                   rsp_ev_ff, rsp_ev_in;
   logic [ID_WIDTH-1:0]    rsp_evid_ff, rsp_evid_in;
   logic [COUNT_WIDTH-1:0] rsp_total_ff, rsp_total_in;

   // Frame limit CSR
   assign frames_in = csr_wr_en ? csr_wr_data : frames_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= CSR_RESET;
      end else begin
         frames_ff <= frames_in;
      end
   end

   // Request beat goes straight into the engine when it is idle
   assign req_chan.ready = !status.busy;
   assign ctrl.start     = req_chan.valid && !status.busy;
   assign ctrl.out_free  = !rsp_valid_ff || rsp_chan.ready;

   lfu_scan_engine #(
      .SLOTS       (SLOTS),
      .ID_WIDTH    (ID_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .id_in          (req_chan.candidate_id),
      .frames_in_use  (frames_ff),
      .status         (status),
      .res_slot       (res_slot),
      .res_newly      (res_newly),
      .res_evicted    (res_evicted),
      .res_evicted_id (res_evicted_id),
      .res_total      (res_total)
   );

   // Load on done, drop when the sink takes the beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_newly_in = rsp_newly_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_evid_in  = rsp_evid_ff;
      rsp_total_in = rsp_total_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = res_slot;
         rsp_newly_in = res_newly;
         rsp_ev_in    = res_evicted;
         rsp_evid_in  = res_evicted_id;
         rsp_total_in = res_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff  <= rsp_slot_in;
      rsp_newly_ff <= rsp_newly_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_evid_ff  <= rsp_evid_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.slot_used     = rsp_slot_ff;
   assign rsp_chan.newly_posted  = rsp_newly_ff;
   assign rsp_chan.evicted_valid = rsp_ev_ff;
   assign rsp_chan.evicted_id    = rsp_evid_ff;
   assign rsp_chan.vote_total    = rsp_total_ff;

endmodule : lfu_frame_replacement_unit

`default_nettype wire

// File: src/lfu_slot_ram.sv
// Simple dual-port frame table RAM: one write, one registered read per cycle.
`default_nettype none

module lfu_slot_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 29,
   parameter int AW    = 5
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : lfu_slot_ram

`default_nettype wire

// File: src/lfu_scan_engine.sv
// Scan, decide and rank-fix sequencer working on the frame table RAM.
`default_nettype none

module lfu_scan_engine #(
   parameter int SLOTS       = 32,
   parameter int ID_WIDTH    = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                           clock,
   input  wire logic                                           reset,
   input  wire lfu_pkg::lfu_ctrl_type                          ctrl,
   input  wire logic [ID_WIDTH-1:0]                            id_in,
   input  wire lfu_pkg::csr_type                               frames_in_use,
   output lfu_pkg::lfu_status_type                             status,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]        res_slot,
   output logic                                                res_newly,
   output logic                                                res_evicted,
   output logic [ID_WIDTH-1:0]                                 res_evicted_id,
   output logic [COUNT_WIDTH-1:0]                              res_total
);
   import lfu_pkg::*;

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int ENTRY_W = ID_WIDTH + COUNT_WIDTH + SLOT_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
   localparam logic [CNT_W-1:0] IDX_END = CNT_W'(SLOTS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_FIX    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [ID_WIDTH-1:0]    id_ff, id_in_nxt;
   logic [CNT_W-1:0]       limit_ff, limit_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]       posted_ff, posted_in;

   logic                   hit_found_ff, hit_found_in;
   logic [SLOT_W-1:0]      hit_slot_ff, hit_slot_in;
   logic [COUNT_WIDTH-1:0] hit_votes_ff, hit_votes_in;
   logic [SLOT_W-1:0]      hit_rank_ff, hit_rank_in;

   logic                   free_found_ff, free_found_in;
   logic [SLOT_W-1:0]      free_slot_ff, free_slot_in;

   logic                   vic_found_ff, vic_found_in;
   logic [SLOT_W-1:0]      vic_slot_ff, vic_slot_in;
   logic [COUNT_WIDTH-1:0] vic_votes_ff, vic_votes_in;
   logic [SLOT_W-1:0]      vic_rank_ff, vic_rank_in;
   logic [ID_WIDTH-1:0]    vic_id_ff, vic_id_in;

   logic [SLOT_W-1:0]      res_slot_ff, res_slot_in;
   logic                   res_newly_ff, res_newly_in;
   logic                   res_ev_ff, res_ev_in;
   logic [ID_WIDTH-1:0]    res_evid_ff, res_evid_in;
   logic [COUNT_WIDTH-1:0] res_total_ff, res_total_in;

   // RAM port
   logic                   wr_en;
   logic [SLOT_W-1:0]      wr_addr;
   logic [ENTRY_W-1:0]     wr_data;
   logic                   rd_en;
   logic [SLOT_W-1:0]      rd_addr;
   logic [ENTRY_W-1:0]     rd_data;

   // Entry returned for the slot read in the cycle before
   logic [CNT_W-1:0]       prev_idx;
   logic [SLOT_W-1:0]      prev_slot;
   logic                   prev_valid;
   logic [ID_WIDTH-1:0]    rd_id;
   logic [COUNT_WIDTH-1:0] rd_votes;
   logic [SLOT_W-1:0]      rd_rank;
   logic [CNT_W-1:0]       limit_calc;
   logic [COUNT_WIDTH-1:0] hit_next_votes;

   lfu_slot_ram #(
      .DEPTH (SLOTS),
      .WIDTH (ENTRY_W),
      .AW    (SLOT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign prev_idx   = idx_ff - CNT_W'(1);
   assign prev_slot  = prev_idx[SLOT_W-1:0];
   assign prev_valid = valid_ff[prev_slot];
   assign rd_id      = rd_data[ENTRY_W-1 -: ID_WIDTH];
   assign rd_votes   = rd_data[SLOT_W +: COUNT_WIDTH];
   assign rd_rank    = rd_data[SLOT_W-1:0];
   assign hit_next_votes = (hit_votes_ff == COUNT_MAX) ? hit_votes_ff
                                                       : hit_votes_ff + COUNT_ONE;

   // Zero acts as one, anything above the table size as the table size
   always_comb begin
      if (frames_in_use == '0) begin
         limit_calc = CNT_W'(1);
      end else if (int'(frames_in_use) > SLOTS) begin
         limit_calc = IDX_END;
      end else begin
         limit_calc = CNT_W'(frames_in_use);
      end
   end

   always_comb begin
      state_in      = state_ff;
      id_in_nxt     = id_ff;
      limit_in      = limit_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      posted_in     = posted_ff;
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_votes_in  = hit_votes_ff;
      hit_rank_in   = hit_rank_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      vic_found_in  = vic_found_ff;
      vic_slot_in   = vic_slot_ff;
      vic_votes_in  = vic_votes_ff;
      vic_rank_in   = vic_rank_ff;
      vic_id_in     = vic_id_ff;
      res_slot_in   = res_slot_ff;
      res_newly_in  = res_newly_ff;
      res_ev_in     = res_ev_ff;
      res_evid_in   = res_evid_ff;
      res_total_in  = res_total_ff;
      wr_en         = 1'b0;
      wr_addr       = prev_slot;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[SLOT_W-1:0];
      status.busy   = 1'b1;
      status.done   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            status.busy = 1'b0;
            if (ctrl.start) begin
               id_in_nxt     = id_in;
               limit_in      = limit_calc;
               idx_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               vic_found_in  = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            rd_en = (idx_ff != IDX_END);
            if (idx_ff != '0) begin
               if (prev_valid) begin
                  if (!hit_found_ff && rd_id == id_ff) begin
                     hit_found_in = 1'b1;
                     hit_slot_in  = prev_slot;
                     hit_votes_in = rd_votes;
                     hit_rank_in  = rd_rank;
                  end
                  if (!vic_found_ff || rd_votes < vic_votes_ff ||
                      (rd_votes == vic_votes_ff && rd_rank < vic_rank_ff)) begin
                     vic_found_in = 1'b1;
                     vic_slot_in  = prev_slot;
                     vic_votes_in = rd_votes;
                     vic_rank_in  = rd_rank;
                     vic_id_in    = rd_id;
                  end
               end else if (!free_found_ff && prev_idx < limit_ff) begin
                  free_found_in = 1'b1;
                  free_slot_in  = prev_slot;
               end
            end
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == IDX_END) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            res_evid_in = '0;
            res_ev_in   = 1'b0;
            wr_en       = 1'b1;
            priority if (hit_found_ff) begin
               wr_addr      = hit_slot_ff;
               wr_data      = {id_ff, hit_next_votes, hit_rank_ff};
               res_slot_in  = hit_slot_ff;
               res_newly_in = 1'b0;
               res_total_in = hit_next_votes;
               state_in     = ST_FINISH;
            end else if (free_found_ff) begin
               wr_addr      = free_slot_ff;
               wr_data      = {id_ff, COUNT_ONE, posted_ff[SLOT_W-1:0]};
               valid_in[free_slot_ff] = 1'b1;
               posted_in    = posted_ff + CNT_W'(1);
               res_slot_in  = free_slot_ff;
               res_newly_in = 1'b1;
               res_total_in = COUNT_ONE;
               state_in     = ST_FINISH;
            end else begin
               // Victim takes the newest rank; later ranks close up in the fix pass
               wr_addr      = vic_slot_ff;
               wr_data      = {id_ff, COUNT_ONE, posted_ff[SLOT_W-1:0] - SLOT_W'(1)};
               res_slot_in  = vic_slot_ff;
               res_newly_in = 1'b1;
               res_ev_in    = 1'b1;
               res_evid_in  = vic_id_ff;
               res_total_in = COUNT_ONE;
               idx_in       = '0;
               state_in     = ST_FIX;
            end
         end

         ST_FIX: begin
            rd_en   = (idx_ff != IDX_END);
            wr_data = {rd_id, rd_votes, rd_rank - SLOT_W'(1)};
            if (idx_ff != '0 && prev_valid && prev_slot != vic_slot_ff &&
                rd_rank > vic_rank_ff) begin
               wr_en = 1'b1;
            end
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff == IDX_END) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (ctrl.out_free) begin
               status.done = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         posted_ff <= '0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         posted_ff <= posted_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in_nxt;
      limit_ff      <= limit_in;
      idx_ff        <= idx_in;
      hit_found_ff  <= hit_found_in;
      hit_slot_ff   <= hit_slot_in;
      hit_votes_ff  <= hit_votes_in;
      hit_rank_ff   <= hit_rank_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      vic_found_ff  <= vic_found_in;
      vic_slot_ff   <= vic_slot_in;
      vic_votes_ff  <= vic_votes_in;
      vic_rank_ff   <= vic_rank_in;
      vic_id_ff     <= vic_id_in;
      res_slot_ff   <= res_slot_in;
      res_newly_ff  <= res_newly_in;
      res_ev_ff     <= res_ev_in;
      res_evid_ff   <= res_evid_in;
      res_total_ff  <= res_total_in;
   end

   assign res_slot       = res_slot_ff;
   assign res_newly      = res_newly_ff;
   assign res_evicted    = res_ev_ff;
   assign res_evicted_id = res_evid_ff;
   assign res_total      = res_total_ff;

endmodule : lfu_scan_engine

`default_nettype wire
